### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/sidta_pkg.sv
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared constants and types of the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package sidta_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int BCD_WIDTH           = 4;

   // ASCII codes
   localparam logic [6:0] CHAR_MINUS = 7'd45;
   localparam logic [6:0] CHAR_ZERO  = 7'd48;
   localparam logic [6:0] CHAR_NINE  = 7'd57;

   // Shift-and-add-3 correction
   localparam logic [BCD_WIDTH-1:0] BCD_ADJUST_MIN = 4'd5;
   localparam logic [BCD_WIDTH-1:0] BCD_ADJUST_ADD = 4'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } dd_status_type;

   typedef enum logic [3:0] {
      EMIT_IDLE  = 4'b0001,
      EMIT_SIGN  = 4'b0010,
      EMIT_SKIP  = 4'b0100,
      EMIT_DIGIT = 4'b1000
   } emit_state_type;

endpackage

`default_nettype wire

### hw/rtl/sidta_if.sv
// ----------------------------------------------------------------------------
// sidta_if
// Valid/ready channels: the integer request and the character response.
// ----------------------------------------------------------------------------
`default_nettype none

interface sidta_req_if #(
   parameter int VALUE_WIDTH = sidta_pkg::DEFAULT_VALUE_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sidta_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed two's-complement integer in, decimal ASCII characters out.
// ----------------------------------------------------------------------------
// Each accepted value comes out as its decimal text, most significant
// character first, with a leading '-' for negative values and last set on
// the final character; the most negative value prints its full magnitude.
// An item first passes through the shift-and-add-3 converter (one magnitude
// bit per cycle), which hands the BCD word to the character sequencer; the
// sequencer sends the sign of a negative value, drops leading zeros and then
// sends one character per digit, each held while the response side holds it
// off. Leading zeros and digits always span (VALUE_WIDTH+2)/3 digit
// positions. No new value is taken until the final character of the previous
// one sits in the output register; a new value is taken as soon as it does.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sidta_pkg::DEFAULT_VALUE_WIDTH
) (
   input wire logic    clock,
   input wire logic    reset,
   sidta_req_if.sink   req_ch,
   sidta_rsp_if.source rsp_ch
);

   localparam int NumDigits = (VALUE_WIDTH + 2) / 3;
   localparam int BcdBits   = sidta_pkg::BCD_WIDTH * NumDigits;

   sidta_pkg::dd_status_type dd_status;
   logic [BcdBits-1:0]       bcd;
   logic [VALUE_WIDTH-1:0]   raw;
   logic [VALUE_WIDTH-1:0]   magnitude;
   logic                     accept;
   logic                     emit_idle;
   logic                     neg_ff, neg_in;

   assign raw       = req_ch.value;
   assign magnitude = raw[VALUE_WIDTH-1] ? ('0 - raw) : raw;
   assign req_ch.ready = !dd_status.busy && !dd_status.done && emit_idle;
   assign accept    = req_ch.valid && req_ch.ready;
   assign neg_in    = accept ? raw[VALUE_WIDTH-1] : neg_ff;

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
   end

   sidta_dd #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dd (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .magnitude(magnitude),
      .status   (dd_status),
      .bcd      (bcd)
   );

   sidta_emit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .start        (dd_status.done),
      .negative     (neg_ff),
      .bcd          (bcd),
      .idle         (emit_idle),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_character(rsp_ch.character),
      .rsp_last     (rsp_ch.last)
   );

endmodule

`default_nettype wire

### hw/rtl/sidta_dd.sv
// ----------------------------------------------------------------------------
// sidta_dd
// Shift-and-add-3 binary to BCD converter, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sidta_dd #(
   parameter int VALUE_WIDTH = sidta_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        start,
   input  wire logic [VALUE_WIDTH-1:0]                      magnitude,
   output      sidta_pkg::dd_status_type                    status,
   output      logic [sidta_pkg::BCD_WIDTH*((VALUE_WIDTH+2)/3)-1:0] bcd
);

   localparam int NumDigits = (VALUE_WIDTH + 2) / 3;
   localparam int BcdBits   = sidta_pkg::BCD_WIDTH * NumDigits;
   localparam int CntWidth  = $clog2(VALUE_WIDTH + 1);

   logic [BcdBits-1:0]     bcd_ff, bcd_in, bcd_adj;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         bcd_adj[sidta_pkg::BCD_WIDTH*i +: sidta_pkg::BCD_WIDTH] =
            (bcd_ff[sidta_pkg::BCD_WIDTH*i +: sidta_pkg::BCD_WIDTH] >=
             sidta_pkg::BCD_ADJUST_MIN) ?
            bcd_ff[sidta_pkg::BCD_WIDTH*i +: sidta_pkg::BCD_WIDTH] +
               sidta_pkg::BCD_ADJUST_ADD :
            bcd_ff[sidta_pkg::BCD_WIDTH*i +: sidta_pkg::BCD_WIDTH];
      end
   end

   always_comb begin
      bcd_in  = bcd_ff;
      bin_in  = bin_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         // adjust then shift one magnitude bit into the BCD word
         bcd_in = {bcd_adj[BcdBits-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CntWidth'(1);
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         bcd_in  = '0;
         bin_in  = magnitude;
         cnt_in  = CntWidth'(VALUE_WIDTH);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

`default_nettype wire

### hw/rtl/sidta_emit.sv
// ----------------------------------------------------------------------------
// sidta_emit
// Character sequencer: sign, leading-zero skip, digits, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sidta_emit #(
   parameter int VALUE_WIDTH = sidta_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        start,
   input  wire logic                                        negative,
   input  wire logic [sidta_pkg::BCD_WIDTH*((VALUE_WIDTH+2)/3)-1:0] bcd,
   output      logic                                        idle,
   output      logic                                        rsp_valid,
   input  wire logic                                        rsp_ready,
   output      logic [6:0]                                  rsp_character,
   output      logic                                        rsp_last
);

   localparam int NumDigits = (VALUE_WIDTH + 2) / 3;
   localparam int BcdBits   = sidta_pkg::BCD_WIDTH * NumDigits;
   localparam int LeftWidth = $clog2(NumDigits + 1);

   sidta_pkg::emit_state_type state_ff, state_in;
   logic [BcdBits-1:0]        dig_ff, dig_in;
   logic [LeftWidth-1:0]      left_ff, left_in;
   logic                      valid_ff, valid_in;
   logic [6:0]                char_ff, char_in;
   logic                      last_ff, last_in;
   logic                      slot_free;
   logic [3:0]                top_digit;
   logic                      final_digit;

   assign slot_free   = !valid_ff || rsp_ready;
   assign top_digit   = dig_ff[BcdBits-1 -: sidta_pkg::BCD_WIDTH];
   assign final_digit = (left_ff == LeftWidth'(1));

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      left_in  = left_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (slot_free) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         sidta_pkg::EMIT_IDLE: begin
            if (start) begin
               dig_in   = bcd;
               left_in  = LeftWidth'(NumDigits);
               state_in = negative ? sidta_pkg::EMIT_SIGN : sidta_pkg::EMIT_SKIP;
            end
         end
         sidta_pkg::EMIT_SIGN: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = sidta_pkg::CHAR_MINUS;
               last_in  = 1'b0;
               state_in = sidta_pkg::EMIT_SKIP;
            end
         end
         sidta_pkg::EMIT_SKIP: begin
            // drop leading zeros, but keep the units digit
            if (top_digit == '0 && !final_digit) begin
               dig_in  = {dig_ff[BcdBits-sidta_pkg::BCD_WIDTH-1:0],
                          {sidta_pkg::BCD_WIDTH{1'b0}}};
               left_in = left_ff - LeftWidth'(1);
            end else begin
               state_in = sidta_pkg::EMIT_DIGIT;
            end
         end
         sidta_pkg::EMIT_DIGIT: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = sidta_pkg::CHAR_ZERO + {3'b000, top_digit};
               last_in  = final_digit;
               dig_in   = {dig_ff[BcdBits-sidta_pkg::BCD_WIDTH-1:0],
                           {sidta_pkg::BCD_WIDTH{1'b0}}};
               left_in  = left_ff - LeftWidth'(1);
               if (final_digit) begin
                  state_in = sidta_pkg::EMIT_IDLE;
               end
            end
         end
         default: begin
            state_in = sidta_pkg::EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sidta_pkg::EMIT_IDLE;
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign idle          = (state_ff == sidta_pkg::EMIT_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

### hw/rtl/sidta_checker.sv
// ----------------------------------------------------------------------------
// sidta_checker
// Port-level checks of the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sidta_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] rsp_character,
   input wire logic       rsp_last
);

   logic [7:0] rsp_item;
   logic       rsp_stall;
   logic       char_ok;

   assign rsp_item  = {rsp_character, rsp_last};
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign char_ok   = (rsp_character == sidta_pkg::CHAR_MINUS && !rsp_last) ||
                      (rsp_character >= sidta_pkg::CHAR_ZERO &&
                       rsp_character <= sidta_pkg::CHAR_NINE);

   // a stalled item holds
   `ASSERT_IMPLIES_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_item))

   // busy right after taking a value
   `ASSERT_IMPLIES_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // no new value while a run is still being sent
   `ASSERT_IMPLIES(a_busy_mid_run, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // only sign or digit characters, and the sign never ends a run
   `ASSERT_IMPLIES(a_char_legal, clock, reset, rsp_valid, char_ok)

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_character(rsp_ch.character),
   .rsp_last     (rsp_ch.last)
);

`default_nettype wire
